### design/kcl_pkg.sv
`timescale 1ns / 1ps

package kcl_pkg;

    // Field widths
    localparam int EVENT_W    = 3;
    localparam int KEY_CODE_W = 4;
    localparam int KEYS_W     = 4;
    localparam int FAIL_W     = 4;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Defaults for the top-level parameters
    localparam int MAX_KEYS_DEF   = 8;
    localparam int TIMER_BITS_DEF = 32;

    // The code register holds this many key slots; later positions expect key 0
    localparam int CODE_SLOTS = 8;

    // Event codes
    localparam logic [EVENT_W-1:0] EV_NONE     = 3'd0;
    localparam logic [EVENT_W-1:0] EV_TAKEN    = 3'd1;
    localparam logic [EVENT_W-1:0] EV_CORRECT  = 3'd2;
    localparam logic [EVENT_W-1:0] EV_WRONG    = 3'd3;
    localparam logic [EVENT_W-1:0] EV_LOCKED   = 3'd4;
    localparam logic [EVENT_W-1:0] EV_UNLOCKED = 3'd5;
    localparam logic [EVENT_W-1:0] EV_IGNORED  = 3'd6;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_CODE_KEYS     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CODE_LENGTH   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_FAILURES  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_LOCKOUT_TICKS = 3'd3;

    // Configuration reset values
    localparam logic [31:0]       CODE_KEYS_RST     = 32'h0000_0213;
    localparam logic [3:0]        CODE_LENGTH_RST   = 4'd3;
    localparam logic [FAIL_W-1:0] MAX_FAILURES_RST  = 4'd3;
    localparam logic [31:0]       LOCKOUT_TICKS_RST = 32'd10000;

    localparam logic [FAIL_W-1:0] FAIL_SAT = 4'd15;

    // Work on the item at the commit point
    typedef struct packed {
        logic                  go;     // item leaves the input register this cycle
        logic                  tick;   // millisecond tick rather than key press
        logic [KEY_CODE_W-1:0] code;   // row*4 + col
    } kcl_step_t;

    // Status of the code entry for the key being committed
    typedef struct packed {
        logic done;    // entry reaches the code length with this key
        logic match;   // all positions equal the configured code
    } kcl_entry_stat_t;

endpackage

### design/kcl_entry.sv
`timescale 1ns / 1ps

// Key entry buffer: stores keys of the current entry and compares a finished
// entry against the configured code.
module kcl_entry #(
    parameter int MAX_KEYS = kcl_pkg::MAX_KEYS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            key_go,
    input  logic [kcl_pkg::KEY_CODE_W-1:0]  key_code,
    input  logic [31:0]                     code_keys,
    input  logic [3:0]                      code_length,
    output kcl_pkg::kcl_entry_stat_t        stat,
    output logic [$clog2(MAX_KEYS+1)-1:0]   count_next
);

    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int IW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int KW = kcl_pkg::KEY_CODE_W;

    logic [KW-1:0]           keys_reg [MAX_KEYS];
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_plus;
    logic [CW-1:0]           len;
    logic [4:0]              len_raw;
    logic [KW*MAX_KEYS+31:0] exp_wide;
    logic                    mismatch;

    // 0 acts as 1, anything past the buffer depth acts as the depth
    always_comb
    begin
        len_raw = {1'b0, code_length};
        if (len_raw == 5'd0)
        begin
            len = CW'(1);
        end
        else if (len_raw > 5'(MAX_KEYS))
        begin
            len = CW'(MAX_KEYS);
        end
        else
        begin
            len = CW'(len_raw);
        end
    end

    assign exp_wide   = {(KW*MAX_KEYS)'(0), code_keys};
    assign count_plus = count_reg + CW'(1);

    // Compare with the new key folded in at its slot
    always_comb
    begin
        mismatch = 1'b0;
        for (int i = 0; i < MAX_KEYS; i++)
        begin
            if (CW'(i) < len)
            begin
                if (CW'(i) == count_reg)
                begin
                    if (key_code != exp_wide[KW*i +: KW])
                    begin
                        mismatch = 1'b1;
                    end
                end
                else if (keys_reg[i] != exp_wide[KW*i +: KW])
                begin
                    mismatch = 1'b1;
                end
            end
        end
    end

    assign stat.done  = (count_plus >= len);
    assign stat.match = !mismatch;
    assign count_next = stat.done ? '0 : count_plus;

    always_ff @(posedge clk)
    begin
        if (key_go)
        begin
            keys_reg[count_reg[IW-1:0]] <= key_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (key_go)
        begin
            count_reg <= count_next;
        end
    end

endmodule

### design/kcl_guard.sv
`timescale 1ns / 1ps

// Failure counter, lock flag and lockout timer; decides the event code.
module kcl_guard #(
    parameter int TIMER_BITS = kcl_pkg::TIMER_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  kcl_pkg::kcl_step_t             step,
    input  kcl_pkg::kcl_entry_stat_t       stat,
    input  logic [kcl_pkg::FAIL_W-1:0]     max_failures,
    input  logic [31:0]                    lockout_ticks,
    output logic                           locked,
    output logic [kcl_pkg::EVENT_W-1:0]    event_next,
    output logic                           locked_next,
    output logic [kcl_pkg::FAIL_W-1:0]     failures_next
);

    logic                          locked_reg;
    logic [kcl_pkg::FAIL_W-1:0]    failures_reg;
    logic [TIMER_BITS-1:0]         timer_reg;
    logic [TIMER_BITS-1:0]         timer_next;
    logic [TIMER_BITS-1:0]         timer_inc;
    logic [kcl_pkg::FAIL_W-1:0]    fail_inc;

    assign timer_inc = (timer_reg == '1) ? timer_reg : timer_reg + TIMER_BITS'(1);
    assign fail_inc  = (failures_reg == kcl_pkg::FAIL_SAT) ? failures_reg
                                                            : failures_reg + 4'd1;

    always_comb
    begin
        event_next    = kcl_pkg::EV_NONE;
        locked_next   = locked_reg;
        failures_next = failures_reg;
        timer_next    = timer_reg;
        priority if (step.tick)
        begin
            if (locked_reg)
            begin
                if (timer_inc >= lockout_ticks[TIMER_BITS-1:0])
                begin
                    locked_next = 1'b0;
                    timer_next  = '0;
                    event_next  = kcl_pkg::EV_UNLOCKED;
                end
                else
                begin
                    timer_next = timer_inc;
                end
            end
        end
        else if (locked_reg)
        begin
            event_next = kcl_pkg::EV_IGNORED;
        end
        else if (!stat.done)
        begin
            event_next = kcl_pkg::EV_TAKEN;
        end
        else if (stat.match)
        begin
            failures_next = '0;
            event_next    = kcl_pkg::EV_CORRECT;
        end
        else
        begin
            failures_next = fail_inc;
            if (fail_inc >= max_failures)
            begin
                locked_next = 1'b1;
                timer_next  = '0;
                event_next  = kcl_pkg::EV_LOCKED;
            end
            else
            begin
                event_next = kcl_pkg::EV_WRONG;
            end
        end
    end

    assign locked = locked_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            locked_reg   <= 1'b0;
            failures_reg <= '0;
            timer_reg    <= '0;
        end
        else if (step.go)
        begin
            locked_reg   <= locked_next;
            failures_reg <= failures_next;
            timer_reg    <= timer_next;
        end
    end

endmodule

### design/keypad_code_lock_core.sv
`timescale 1ns / 1ps

// Keypad code lock with lockout. Each item is either a key press (mode 0,
// key code row*4+col) or a millisecond tick (mode 1) and produces exactly one
// result item: an event code, the lock flag, the number of keys held in the
// current entry and the failure count, all as they stand after the item.
// Throughput is one item per clock while no stall holds it back; each item
// passes the input register and then the result register, with the
// per-item update (entry compare, failure count, lockout timer compare)
// done combinationally between them. Both channels use valid/stall;
// in_stall rises only when the input register holds an item that cannot
// move because the result register is full and stalled. Configuration is a
// plain write port (cfg_we, cfg_addr, cfg_wdata) and should only be written
// with no items in flight. Stored keys need no clearing: a slot is compared
// only after it was written in the same entry.
module keypad_code_lock_core #(
    parameter int MAX_KEYS   = kcl_pkg::MAX_KEYS_DEF,
    parameter int TIMER_BITS = kcl_pkg::TIMER_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_we,
    input  logic [kcl_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [kcl_pkg::CFG_DATA_W-1:0]    cfg_wdata,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              mode,
    input  logic [1:0]                        key_row,
    input  logic [1:0]                        key_col,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [kcl_pkg::EVENT_W-1:0]       event_res,
    output logic                              is_locked,
    output logic [kcl_pkg::KEYS_W-1:0]        keys_entered,
    output logic [kcl_pkg::FAIL_W-1:0]        failure_count
);

    localparam int CW = $clog2(MAX_KEYS + 1);

    // Configuration registers
    logic [31:0]                  code_keys_reg;
    logic [3:0]                   code_length_reg;
    logic [kcl_pkg::FAIL_W-1:0]   max_failures_reg;
    logic [31:0]                  lockout_ticks_reg;

    // Input register
    logic                              s1_valid_reg;
    logic                              s1_valid_next;
    logic                              s1_tick_reg;
    logic [kcl_pkg::KEY_CODE_W-1:0]    s1_code_reg;

    // Result register
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [kcl_pkg::EVENT_W-1:0]       event_reg;
    logic                              locked_out_reg;
    logic [kcl_pkg::KEYS_W-1:0]        keys_reg;
    logic [kcl_pkg::FAIL_W-1:0]        fail_out_reg;

    logic                              in_take;
    logic                              locked;
    logic                              key_go;
    logic [CW-1:0]                     count_next;
    logic [kcl_pkg::EVENT_W-1:0]       event_next;
    logic                              locked_next;
    logic [kcl_pkg::FAIL_W-1:0]        failures_next;
    logic [kcl_pkg::KEYS_W-1:0]        keys_next;
    logic [kcl_pkg::KEYS_W-1:0]        u_entry_count_hold;
    kcl_pkg::kcl_step_t                step;
    kcl_pkg::kcl_entry_stat_t          stat;

    // Config writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_keys_reg     <= kcl_pkg::CODE_KEYS_RST;
            code_length_reg   <= kcl_pkg::CODE_LENGTH_RST;
            max_failures_reg  <= kcl_pkg::MAX_FAILURES_RST;
            lockout_ticks_reg <= kcl_pkg::LOCKOUT_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                kcl_pkg::REG_CODE_KEYS:     code_keys_reg     <= cfg_wdata;
                kcl_pkg::REG_CODE_LENGTH:   code_length_reg   <= cfg_wdata[3:0];
                kcl_pkg::REG_MAX_FAILURES:  max_failures_reg  <= cfg_wdata[3:0];
                kcl_pkg::REG_LOCKOUT_TICKS: lockout_ticks_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // The item in the input register commits whenever the result register
    // is empty or being drained this cycle.
    assign step.go   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign step.tick = s1_tick_reg;
    assign step.code = s1_code_reg;

    assign in_stall = s1_valid_reg && !step.go;
    assign in_take  = in_valid && !in_stall;

    assign s1_valid_next  = in_take || (s1_valid_reg && !step.go);
    assign out_valid_next = step.go || (out_valid_reg && out_stall);

    // Only key presses on an unlocked keypad touch the entry buffer
    assign key_go = step.go && !step.tick && !locked;

    kcl_entry #(
        .MAX_KEYS (MAX_KEYS)
    ) u_entry (
        .clk         (clk),
        .rst_n       (rst_n),
        .key_go      (key_go),
        .key_code    (step.code),
        .code_keys   (code_keys_reg),
        .code_length (code_length_reg),
        .stat        (stat),
        .count_next  (count_next)
    );

    kcl_guard #(
        .TIMER_BITS (TIMER_BITS)
    ) u_guard (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .stat          (stat),
        .max_failures  (max_failures_reg),
        .lockout_ticks (lockout_ticks_reg),
        .locked        (locked),
        .event_next    (event_next),
        .locked_next   (locked_next),
        .failures_next (failures_next)
    );

    // Count held after the item: unchanged unless a key was taken
    assign keys_next = key_go ? kcl_pkg::KEYS_W'(count_next)
                              : kcl_pkg::KEYS_W'(u_entry_count_hold);

    // Track the held count locally for ticks and ignored keys
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_entry_count_hold <= '0;
        end
        else if (key_go)
        begin
            u_entry_count_hold <= kcl_pkg::KEYS_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_tick_reg <= mode;
            s1_code_reg <= {key_row, key_col};
        end
        if (step.go)
        begin
            event_reg      <= event_next;
            locked_out_reg <= locked_next;
            keys_reg       <= keys_next;
            fail_out_reg   <= failures_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_res     = event_reg;
    assign is_locked     = locked_out_reg;
    assign keys_entered  = keys_reg;
    assign failure_count = fail_out_reg;

    // A lock event always reports the keypad locked, an unlock event unlocked
    a_lock_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == kcl_pkg::EV_LOCKED |-> is_locked)
        else $error("locked event without lock flag");

    a_unlock_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == kcl_pkg::EV_UNLOCKED |-> !is_locked)
        else $error("unlocked event with lock flag set");

    // A correct entry clears failures and the entry buffer
    a_correct_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == kcl_pkg::EV_CORRECT
        |-> failure_count == '0 && keys_entered == '0)
        else $error("correct entry left failures or keys behind");

    // Finished entries leave no keys held
    a_entry_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == kcl_pkg::EV_WRONG || event_res == kcl_pkg::EV_LOCKED)
        |-> keys_entered == '0)
        else $error("finished entry left keys held");

    // The input side stalls only behind a blocked result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled without a blocked result");

endmodule

### test/keypad_code_lock_core_tb.sv
`timescale 1ns / 1ps

module keypad_code_lock_core_tb;

    // Generous cap on the whole run, in clock cycles
    localparam int unsigned CYCLE_LIMIT = 400000;
    // Register index outside the defined set; writes to it must be dropped
    localparam logic [kcl_pkg::CFG_ADDR_W-1:0] REG_SPARE = 3'd7;

    // One item on the input channel: a key press or a millisecond tick
    typedef struct packed {
        logic       tick;
        logic [1:0] row;
        logic [1:0] col;
    } keypad_item_t;

    // One item on the result channel
    typedef struct packed {
        logic [kcl_pkg::EVENT_W-1:0] ev;
        logic                        locked;
        logic [kcl_pkg::KEYS_W-1:0]  keys;
        logic [kcl_pkg::FAIL_W-1:0]  fails;
    } lock_status_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [kcl_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [kcl_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic                           mode = 1'b0;
    logic [1:0]                     key_row = '0;
    logic [1:0]                     key_col = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [kcl_pkg::EVENT_W-1:0]    event_res;
    logic                           is_locked;
    logic [kcl_pkg::KEYS_W-1:0]     keys_entered;
    logic [kcl_pkg::FAIL_W-1:0]     failure_count;

    keypad_code_lock_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .key_row       (key_row),
        .key_col       (key_col),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_res     (event_res),
        .is_locked     (is_locked),
        .keys_entered  (keys_entered),
        .failure_count (failure_count)
    );

    // Items waiting to be offered, and statuses waiting to come out
    keypad_item_t keypad_items[$];
    lock_status_t awaited_status[$];

    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned items_accepted = 0;

    // Mirror of the configuration registers
    logic [31:0]                code_keys_m     = kcl_pkg::CODE_KEYS_RST;
    logic [3:0]                 code_length_m   = kcl_pkg::CODE_LENGTH_RST;
    logic [kcl_pkg::FAIL_W-1:0] max_failures_m  = kcl_pkg::MAX_FAILURES_RST;
    logic [31:0]                lockout_ticks_m = kcl_pkg::LOCKOUT_TICKS_RST;

    // Mirror of the lock state
    logic [kcl_pkg::KEY_CODE_W-1:0] stored_keys [kcl_pkg::MAX_KEYS_DEF];
    int unsigned                    stored_count = 0;
    logic [kcl_pkg::FAIL_W-1:0]     fail_tally = '0;
    logic                           lock_active = 1'b0;
    logic [31:0]                    lockout_elapsed = '0;

    // Sender and receiver idling state
    int unsigned tx_gap_left = 0;
    int unsigned tx_calm_left = 0;
    int unsigned rx_gap_left = 0;
    int unsigned rx_calm_left = 0;
    // Long receiver hold-off, owned by its own process
    int unsigned hold_left = 0;
    int unsigned next_hold_at = 150;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Code length as the lock applies it: 0 means 1, long codes clip to MAX_KEYS
    function automatic int unsigned code_span();
        if (code_length_m == 0)
            return 1;
        if (code_length_m > kcl_pkg::MAX_KEYS_DEF)
            return kcl_pkg::MAX_KEYS_DEF;
        return code_length_m;
    endfunction

    // Expected key at a code position; slots past the register expect key 0
    function automatic logic [3:0] code_nibble(input int unsigned pos);
        if (pos >= kcl_pkg::CODE_SLOTS)
            return 4'd0;
        return code_keys_m[4*pos +: 4];
    endfunction

    // Advance the lock mirror by one item and return the status it reports
    function automatic lock_status_t next_lock_status(input keypad_item_t it);
        lock_status_t res;
        int unsigned  need;
        int unsigned  i;
        logic         good;
        res.ev = kcl_pkg::EV_NONE;
        if (it.tick)
        begin
            if (lock_active)
            begin
                if (lockout_elapsed != '1)
                    lockout_elapsed = lockout_elapsed + 32'd1;
                if (lockout_elapsed >= lockout_ticks_m)
                begin
                    lock_active = 1'b0;
                    lockout_elapsed = '0;
                    res.ev = kcl_pkg::EV_UNLOCKED;
                end
            end
        end
        else if (lock_active)
        begin
            res.ev = kcl_pkg::EV_IGNORED;
        end
        else
        begin
            need = code_span();
            if (stored_count < kcl_pkg::MAX_KEYS_DEF)
                stored_keys[stored_count] = {it.row, it.col};
            stored_count++;
            if (stored_count >= need)
            begin
                good = 1'b1;
                for (i = 0; i < need; i++)
                    if (stored_keys[i] != code_nibble(i))
                        good = 1'b0;
                if (good)
                begin
                    fail_tally = '0;
                    res.ev = kcl_pkg::EV_CORRECT;
                end
                else
                begin
                    if (fail_tally < kcl_pkg::FAIL_SAT)
                        fail_tally++;
                    if (fail_tally >= max_failures_m)
                    begin
                        lock_active = 1'b1;
                        lockout_elapsed = '0;
                        res.ev = kcl_pkg::EV_LOCKED;
                    end
                    else
                    begin
                        res.ev = kcl_pkg::EV_WRONG;
                    end
                end
                stored_count = 0;
            end
            else
            begin
                res.ev = kcl_pkg::EV_TAKEN;
            end
        end
        res.locked = lock_active;
        res.keys = stored_count[kcl_pkg::KEYS_W-1:0];
        res.fails = fail_tally;
        return res;
    endfunction

    // Idle length: mostly short, now and then long
    function automatic int unsigned idle_span();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        $display("%0t ns: %s is %0d, should be %0d", $time, what, got, want);
    endtask

    // Driver: counts and predicts each accepted item, then loads the next one.
    // Payload only moves when the current item is gone or none is offered.
    always @(posedge clk)
    begin
        keypad_item_t nxt;
        if (in_valid && !in_stall)
        begin
            awaited_status.push_back(next_lock_status({mode, key_row, key_col}));
            items_accepted <= items_accepted + 1;
        end
        if (!in_valid || !in_stall)
        begin
            if (tx_gap_left != 0)
            begin
                in_valid <= 1'b0;
                tx_gap_left <= tx_gap_left - 1;
            end
            else if (keypad_items.size() != 0)
            begin
                nxt = keypad_items.pop_front();
                in_valid <= 1'b1;
                mode <= nxt.tick;
                key_row <= nxt.row;
                key_col <= nxt.col;
                // gap after this item, unless in a stretch of back-to-back items
                if (tx_calm_left != 0)
                    tx_calm_left <= tx_calm_left - 1;
                else if ($urandom_range(0, 99) < 25)
                    tx_gap_left <= idle_span();
                else if ($urandom_range(0, 99) < 4)
                    tx_calm_left <= $urandom_range(20, 80);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted result against the oldest prediction,
    // then picks the stall for the next cycle.
    always @(posedge clk)
    begin
        lock_status_t want;
        if (out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (awaited_status.size() == 0)
            begin
                report_mismatch("unexpected result, event_res", event_res,
                                kcl_pkg::EV_NONE);
            end
            else
            begin
                want = awaited_status.pop_front();
                if (event_res !== want.ev)
                    report_mismatch("event_res", event_res, want.ev);
                if (is_locked !== want.locked)
                    report_mismatch("is_locked", is_locked, want.locked);
                if (keys_entered !== want.keys)
                    report_mismatch("keys_entered", keys_entered, want.keys);
                if (failure_count !== want.fails)
                    report_mismatch("failure_count", failure_count, want.fails);
            end
        end
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
        end
        else if (rx_gap_left != 0)
        begin
            out_stall <= 1'b1;
            rx_gap_left <= rx_gap_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (rx_calm_left != 0)
                rx_calm_left <= rx_calm_left - 1;
            else if ($urandom_range(0, 99) < 25)
                rx_gap_left <= idle_span();
            else if ($urandom_range(0, 99) < 5)
                rx_calm_left <= $urandom_range(20, 80);
        end
    end

    // Long hold-off every few hundred items, so the block backs up into in_stall
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (items_accepted >= next_hold_at)
        begin
            hold_left <= $urandom_range(80, 140);
            next_hold_at <= next_hold_at + 300;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(input logic [kcl_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            kcl_pkg::REG_CODE_KEYS:     code_keys_m = val;
            kcl_pkg::REG_CODE_LENGTH:   code_length_m = val[3:0];
            kcl_pkg::REG_MAX_FAILURES:  max_failures_m = val[kcl_pkg::FAIL_W-1:0];
            kcl_pkg::REG_LOCKOUT_TICKS: lockout_ticks_m = val;
            default: ;
        endcase
    endtask

    task automatic set_lock_config(input logic [31:0] code, input logic [3:0] len,
                                   input logic [3:0] maxf, input logic [31:0] lockout);
        write_reg(kcl_pkg::REG_CODE_KEYS, code);
        write_reg(kcl_pkg::REG_CODE_LENGTH, {28'd0, len});
        write_reg(kcl_pkg::REG_MAX_FAILURES, {28'd0, maxf});
        write_reg(kcl_pkg::REG_LOCKOUT_TICKS, lockout);
    endtask

    task automatic add_key(input logic [3:0] code);
        keypad_items.push_back({1'b0, code});
    endtask

    // Ticks carry random row/col bits, which the block must ignore
    task automatic add_ticks(input int unsigned n);
        logic [3:0] junk;
        repeat (n)
        begin
            junk = 4'($urandom_range(0, 15));
            keypad_items.push_back({1'b1, junk});
        end
    endtask

    // Wait at the falling edge so all nonblocking updates have settled
    task automatic wait_drained();
        @(negedge clk);
        while (keypad_items.size() != 0 || in_valid || awaited_status.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Random phase built from whole code entries under the current settings.
    // right_pct sets how often an entry is the right code; wrong entries have
    // one key changed, and tick bursts are long enough to sit out a short lockout.
    task automatic queue_phase(input int unsigned count, input int unsigned right_pct);
        int unsigned made;
        int unsigned len;
        int unsigned pick;
        int unsigned i;
        int unsigned bad_pos;
        int unsigned burst;
        logic [3:0]  k;
        logic [3:0]  flip;
        made = 0;
        len = code_span();
        while (made < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < right_pct)
            begin
                for (i = 0; i < len; i++)
                    add_key(code_nibble(i));
                made += len;
            end
            else if (pick < 70)
            begin
                bad_pos = $urandom_range(0, len - 1);
                for (i = 0; i < len; i++)
                begin
                    k = code_nibble(i);
                    if (i == bad_pos)
                    begin
                        flip = 4'($urandom_range(1, 15));
                        k = k ^ flip;
                    end
                    add_key(k);
                end
                made += len;
            end
            else if (pick < 85)
            begin
                burst = (lockout_ticks_m < 40) ? lockout_ticks_m + 1 : $urandom_range(1, 8);
                add_ticks(burst);
                made += burst;
            end
            else
            begin
                // stray keys: knock the entry out of step
                burst = $urandom_range(1, 3);
                repeat (burst)
                begin
                    k = 4'($urandom_range(0, 15));
                    add_key(k);
                end
                made += burst;
            end
        end
        wait_drained();
    endtask

    initial
    begin
        int unsigned i;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset settings (code 3,1,2): right code, tick while open, wrong code
        add_key(4'd3);
        add_key(4'd1);
        add_key(4'd2);
        add_ticks(1);
        add_key(4'd15);
        add_key(4'd0);
        add_key(4'd15);
        wait_drained();

        // Zero lockout: lock, key while locked, one tick opens; relock on next miss
        set_lock_config(kcl_pkg::CODE_KEYS_RST, 4'd3, 4'd2, 32'd0);
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        for (i = 0; i < 3; i++)
            add_key(4'd0);
        add_key(4'd7);
        add_ticks(1);
        for (i = 0; i < 3; i++)
            add_key(4'd5);
        add_ticks(1);
        wait_drained();

        // Length 0 acts as 1; zero max_failures locks on any miss
        set_lock_config(32'hFFFF_FFFF, 4'd0, 4'd0, 32'd2);
        add_key(4'd15);
        add_key(4'd0);
        add_ticks(2);
        wait_drained();

        // Length 15 clips to MAX_KEYS
        set_lock_config(32'h7654_3210, 4'd15, 4'd15, 32'd1);
        for (i = 0; i < 8; i++)
            add_key(i[3:0]);
        wait_drained();

        // Random phases across the register extremes
        set_lock_config($urandom, 4'd4, 4'd3, 32'd5);
        queue_phase(120, 45);
        set_lock_config(32'h0000_0000, 4'd8, 4'd1, 32'd0);
        queue_phase(120, 45);
        // single-key code, mostly misses: failure count reaches saturation
        set_lock_config(32'hFFFF_FFFF, 4'd1, 4'd15, 32'd2);
        queue_phase(120, 5);
        set_lock_config($urandom, 4'd9, 4'd0, 32'd1);
        queue_phase(100, 45);
        // lockout that never runs out within the phase
        set_lock_config($urandom, 4'd0, 4'd2, 32'hFFFF_FFFF);
        queue_phase(40, 30);
        set_lock_config($urandom, 4'd2, 4'd15, 32'd12);
        queue_phase(110, 20);
        set_lock_config($urandom, 4'd15, 4'd4, 32'd30);
        queue_phase(120, 45);
        set_lock_config($urandom, 4'($urandom_range(1, 8)), 4'($urandom_range(1, 15)),
                        32'($urandom_range(0, 20)));
        queue_phase(100, 45);

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
